@@ rtl/cfsp_pkg.sv @@
// cfsp_pkg: shared types and constants of the command frame splitter and parser
// used by every rtl file of the block and by its checker
`timescale 1ns / 1ps

package cfsp_pkg;

    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_G    = 8'h67;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [3:0] POFF_BASE  = 4'd9;
    localparam logic [3:0] POFF_ONE   = 4'd10;
    localparam logic [3:0] POFF_REPLY = 4'd12;

    localparam int NCAP = 10;

    typedef struct packed {
        logic                     ovf;
        logic                     term;
        logic                     kind;
        logic [NCAP-1:0][7:0]     cap;
    } t_track;

    typedef struct packed {
        logic [1:0] status;
        logic       frame_kind;
        logic [7:0] dest_node;
        logic [7:0] src_node;
        logic [7:0] cmd_first;
        logic [7:0] cmd_second;
        logic [7:0] cmd_third;
        logic [7:0] reply_count;
        logic [3:0] param_offset;
        logic [7:0] param_len;
        logic [8:0] frame_length;
    } t_desc;

endpackage

@@ rtl/command_frame_splitter_parser_core.sv @@
// the closing byte of a frame is registered in the byte register; its descriptor is then
// registered in the descriptor register and shown from there
// throughput: one byte per cycle while no output stall holds it; the byte register and the descriptor register
// each advance whenever the next one is free
// reset (synchronous, active low) empties both registers and clears the line state
// depends on cfsp_pkg, cfsp_track, cfsp_desc
`timescale 1ns / 1ps

module command_frame_splitter_parser_core #(
    parameter int LINE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic       o_frame_kind,
    output logic [7:0] o_dest_node,
    output logic [7:0] o_src_node,
    output logic [7:0] o_cmd_first,
    output logic [7:0] o_cmd_second,
    output logic [7:0] o_cmd_third,
    output logic [7:0] o_reply_count,
    output logic [3:0] o_param_offset,
    output logic [7:0] o_param_len,
    output logic [8:0] o_frame_length
);

    localparam int POS_W = $clog2(LINE_DEPTH + 1);
    localparam int LEN_W = (POS_W > 9) ? POS_W : 9;

    logic               r_in_valid, n_in_valid;
    logic [7:0]         r_in_byte, n_in_byte;
    logic               r_out_valid, n_out_valid;
    cfsp_pkg::t_desc    r_out, n_out;
    cfsp_pkg::t_track   trk;
    cfsp_pkg::t_desc    desc;
    logic [LEN_W-1:0]   len;
    logic               out_free, go, load;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign load       = i_in_valid && !o_in_stall;

    cfsp_track #(
        .LINE_DEPTH (LINE_DEPTH),
        .POS_W      (POS_W),
        .LEN_W      (LEN_W)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .o_trk   (trk),
        .o_len   (len)
    );

    cfsp_desc #(
        .LEN_W (LEN_W)
    ) u_desc (
        .i_trk  (trk),
        .i_len  (len),
        .o_desc (desc)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        if (load) begin
            n_in_valid = 1'b1;
            n_in_byte  = i_rx_byte;
        end else if (go) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (go && (trk.ovf || trk.term)) begin
            n_out_valid = 1'b1;
            n_out       = desc;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= n_in_byte;
        r_out     <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_frame_kind   = r_out.frame_kind;
    assign o_dest_node    = r_out.dest_node;
    assign o_src_node     = r_out.src_node;
    assign o_cmd_first    = r_out.cmd_first;
    assign o_cmd_second   = r_out.cmd_second;
    assign o_cmd_third    = r_out.cmd_third;
    assign o_reply_count  = r_out.reply_count;
    assign o_param_offset = r_out.param_offset;
    assign o_param_len    = r_out.param_len;
    assign o_frame_length = r_out.frame_length;

endmodule

@@ rtl/cfsp_track.sv @@
// cfsp_track: line state, six-byte header window and captured header bytes
// depends on cfsp_pkg
`timescale 1ns / 1ps

module cfsp_track #(
    parameter int LINE_DEPTH = 256,
    parameter int POS_W      = 9,
    parameter int LEN_W      = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [7:0]           i_byte,
    output cfsp_pkg::t_track     o_trk,
    output logic [LEN_W-1:0]     o_len
);

    logic [5:0][7:0]                     r_win, n_win, e_win, w;
    logic [POS_W-1:0]                    r_pos, n_pos, e_pos;
    logic [POS_W-1:0]                    r_start, n_start, e_start, off;
    logic                                r_hs, n_hs, e_hs;
    logic                                r_kind, n_kind, e_kind;
    logic [cfsp_pkg::NCAP-1:0][7:0]      r_cap, n_cap, e_cap, cap_w;
    logic                                ovf, hdr, term;

    always_comb begin
        ovf     = (r_pos == POS_W'(LINE_DEPTH));
        e_win   = ovf ? '0 : r_win;
        e_pos   = ovf ? '0 : r_pos;
        e_start = ovf ? '0 : r_start;
        e_hs    = ovf ? 1'b0 : r_hs;
        e_kind  = ovf ? 1'b0 : r_kind;
        e_cap   = ovf ? '0 : r_cap;

        w   = {e_win[4:0], i_byte};
        off = e_pos - e_start;

        cap_w = e_cap;
        for (int k = 0; k < cfsp_pkg::NCAP; k++) begin
            if (e_hs && off == POS_W'(k + 2)) begin
                cap_w[k] = i_byte;
            end
        end

        hdr = (w[5] == cfsp_pkg::CH_C || w[5] == cfsp_pkg::CH_R)
              && w[4] == cfsp_pkg::CH_DASH && w[2] == cfsp_pkg::CH_DASH
              && w[0] == cfsp_pkg::CH_DASH && e_pos >= POS_W'(5);

        n_hs    = e_hs;
        n_start = e_start;
        n_kind  = e_kind;
        n_cap   = cap_w;
        if (hdr) begin
            n_hs     = 1'b1;
            n_start  = e_pos - POS_W'(5);
            n_kind   = (w[5] == cfsp_pkg::CH_R);
            n_cap    = '0;
            n_cap[0] = w[3];
            n_cap[1] = w[2];
            n_cap[2] = w[1];
            n_cap[3] = w[0];
        end

        term = e_hs && w[2] == cfsp_pkg::CH_SP && w[1] == cfsp_pkg::CH_CR
               && w[0] == cfsp_pkg::CH_LF;

        o_len = LEN_W'(e_pos) + LEN_W'(1) - LEN_W'(e_start);

        o_trk.ovf  = ovf;
        o_trk.term = term;
        o_trk.kind = e_kind;
        o_trk.cap  = cap_w;

        n_win = w;
        n_pos = e_pos + POS_W'(1);
        if (term) begin
            n_win   = '0;
            n_pos   = '0;
            n_start = '0;
            n_hs    = 1'b0;
            n_kind  = 1'b0;
            n_cap   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_pos   <= '0;
            r_start <= '0;
            r_hs    <= 1'b0;
            r_kind  <= 1'b0;
            r_cap   <= '0;
        end else if (i_go) begin
            r_win   <= n_win;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_hs    <= n_hs;
            r_kind  <= n_kind;
            r_cap   <= n_cap;
        end
    end

endmodule

@@ rtl/cfsp_desc.sv @@
// cfsp_desc: builds the frame descriptor from the captured header bytes
// depends on cfsp_pkg
`timescale 1ns / 1ps

module cfsp_desc #(
    parameter int LEN_W = 9
) (
    input  cfsp_pkg::t_track     i_trk,
    input  logic [LEN_W-1:0]     i_len,
    output cfsp_pkg::t_desc      o_desc
);

    logic [3:0]       poff;
    logic [7:0]       reply;
    logic [LEN_W-1:0] pend, diff;
    logic [7:0]       plen;
    logic             known;
    logic [7:0]       rcv;

    always_comb begin
        rcv   = i_trk.cap[0];
        known = rcv == cfsp_pkg::CH_C || rcv == cfsp_pkg::CH_P || rcv == cfsp_pkg::CH_M
                || rcv == cfsp_pkg::CH_T || rcv == cfsp_pkg::CH_D || rcv == cfsp_pkg::CH_G;

        priority if (i_trk.cap[7] == cfsp_pkg::CH_DASH && i_trk.cap[9] == cfsp_pkg::CH_DASH) begin
            reply = i_trk.cap[8];
            poff  = cfsp_pkg::POFF_REPLY;
        end else if (i_trk.cap[7] == cfsp_pkg::CH_DASH) begin
            reply = cfsp_pkg::CH_ONE;
            poff  = cfsp_pkg::POFF_ONE;
        end else begin
            reply = cfsp_pkg::CH_ONE;
            poff  = cfsp_pkg::POFF_BASE;
        end

        pend = LEN_W'(poff) + LEN_W'(3);
        diff = i_len - pend;
        plen = (i_len > pend) ? diff[7:0] : 8'd0;

        if (i_trk.ovf) begin
            o_desc        = '0;
            o_desc.status = cfsp_pkg::ST_OVF;
        end else begin
            o_desc.status       = known ? cfsp_pkg::ST_OK : cfsp_pkg::ST_DROP;
            o_desc.frame_kind   = i_trk.kind;
            o_desc.dest_node    = rcv;
            o_desc.src_node     = i_trk.cap[2];
            o_desc.cmd_first    = i_trk.cap[4];
            o_desc.cmd_second   = i_trk.cap[5];
            o_desc.cmd_third    = i_trk.cap[6];
            o_desc.reply_count  = reply;
            o_desc.param_offset = poff;
            o_desc.param_len    = plen;
            o_desc.frame_length = i_len[8:0];
        end
    end

endmodule

@@ rtl/cfsp_checker.sv @@
// cfsp_checker: port-level checks of the frame splitter and parser, with its bind
// depends on cfsp_pkg and command_frame_splitter_parser_core
`timescale 1ns / 1ps

module cfsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic       o_frame_kind,
    input logic [7:0] o_dest_node,
    input logic [7:0] o_reply_count,
    input logic [3:0] o_param_offset,
    input logic [7:0] o_param_len,
    input logic [8:0] o_frame_length
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("item shown right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_frame_length) && $stable(o_dest_node))
        else $error("stalled item changed");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == cfsp_pkg::ST_OVF |->
            o_frame_length == 9'd0 && o_param_offset == 4'd0 && o_param_len == 8'd0
            && o_dest_node == 8'd0 && o_reply_count == 8'd0 && !o_frame_kind)
        else $error("overflow item carries frame fields");

    a_poff_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != cfsp_pkg::ST_OVF |->
            (o_param_offset == cfsp_pkg::POFF_BASE || o_param_offset == cfsp_pkg::POFF_ONE
             || o_param_offset == cfsp_pkg::POFF_REPLY)
            && (o_status == cfsp_pkg::ST_OK || o_status == cfsp_pkg::ST_DROP))
        else $error("bad parameter offset or status");

    a_ok_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == cfsp_pkg::ST_OK |->
            o_dest_node == cfsp_pkg::CH_C || o_dest_node == cfsp_pkg::CH_P
            || o_dest_node == cfsp_pkg::CH_M || o_dest_node == cfsp_pkg::CH_T
            || o_dest_node == cfsp_pkg::CH_D || o_dest_node == cfsp_pkg::CH_G)
        else $error("accepted frame with unknown receiver");

endmodule

bind command_frame_splitter_parser_core cfsp_checker u_cfsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_frame_kind   (o_frame_kind),
    .o_dest_node    (o_dest_node),
    .o_reply_count  (o_reply_count),
    .o_param_offset (o_param_offset),
    .o_param_len    (o_param_len),
    .o_frame_length (o_frame_length)
);

@@ tb/sv/command_frame_splitter_parser_core_tb.sv @@
// testbench for command_frame_splitter_parser_core: serial bytes in, one descriptor per closed
// frame or line overflow out, checked against a scoreboard class that tracks the line state
// depends on cfsp_pkg and command_frame_splitter_parser_core
`timescale 1ns / 1ps

module command_frame_splitter_parser_core_tb;

    localparam int LINE_DEPTH = 256;

    class frame_scoreboard;
        logic [7:0]      win [6];
        logic [7:0]      cap [10];
        int unsigned     line_pos;
        int unsigned     hdr_start;
        bit              hdr_seen;
        bit              hdr_kind;
        cfsp_pkg::t_desc expq [$];
        int unsigned     fails;

        function new();
            fails = 0;
            clear_line();
        endfunction

        function void clear_line();
            foreach (win[k]) win[k] = 8'h00;
            foreach (cap[k]) cap[k] = 8'h00;
            line_pos  = 0;
            hdr_start = 0;
            hdr_seen  = 1'b0;
            hdr_kind  = 1'b0;
        endfunction

        function bit receiver_ok(logic [7:0] r);
            return r == cfsp_pkg::CH_C || r == cfsp_pkg::CH_P || r == cfsp_pkg::CH_M
                || r == cfsp_pkg::CH_T || r == cfsp_pkg::CH_D || r == cfsp_pkg::CH_G;
        endfunction

        function void note_byte(logic [7:0] b);
            cfsp_pkg::t_desc d;
            int unsigned     off;
            int unsigned     len;
            int unsigned     poff;
            logic [7:0]      reply;
            if (line_pos >= LINE_DEPTH) begin
                d = '0;
                d.status = cfsp_pkg::ST_OVF;
                expq.push_back(d);
                clear_line();
            end
            for (int k = 5; k > 0; k--) win[k] = win[k-1];
            win[0] = b;
            if (hdr_seen) begin
                off = line_pos - hdr_start;
                if (off >= 2 && off <= 11) cap[off-2] = b;
            end
            if ((win[5] == cfsp_pkg::CH_C || win[5] == cfsp_pkg::CH_R)
                && win[4] == cfsp_pkg::CH_DASH && win[2] == cfsp_pkg::CH_DASH
                && win[0] == cfsp_pkg::CH_DASH && line_pos >= 5) begin
                hdr_seen  = 1'b1;
                hdr_start = line_pos - 5;
                hdr_kind  = (win[5] == cfsp_pkg::CH_R);
                cap[0] = win[3];
                cap[1] = win[2];
                cap[2] = win[1];
                cap[3] = win[0];
                for (int k = 4; k < 10; k++) cap[k] = 8'h00;
            end
            if (hdr_seen && win[2] == cfsp_pkg::CH_SP && win[1] == cfsp_pkg::CH_CR
                && win[0] == cfsp_pkg::CH_LF) begin
                len = line_pos + 1 - hdr_start;
                if (cap[7] == cfsp_pkg::CH_DASH && cap[9] == cfsp_pkg::CH_DASH) begin
                    reply = cap[8];
                    poff  = cfsp_pkg::POFF_REPLY;
                end else if (cap[7] == cfsp_pkg::CH_DASH) begin
                    reply = cfsp_pkg::CH_ONE;
                    poff  = cfsp_pkg::POFF_ONE;
                end else begin
                    reply = cfsp_pkg::CH_ONE;
                    poff  = cfsp_pkg::POFF_BASE;
                end
                d.status       = receiver_ok(cap[0]) ? cfsp_pkg::ST_OK : cfsp_pkg::ST_DROP;
                d.frame_kind   = hdr_kind;
                d.dest_node    = cap[0];
                d.src_node     = cap[2];
                d.cmd_first    = cap[4];
                d.cmd_second   = cap[5];
                d.cmd_third    = cap[6];
                d.reply_count  = reply;
                d.param_offset = 4'(poff);
                d.param_len    = (len > poff + 3) ? 8'(len - poff - 3) : 8'h00;
                d.frame_length = 9'(len);
                expq.push_back(d);
                clear_line();
                return;
            end
            line_pos++;
        endfunction

        function string show(cfsp_pkg::t_desc d);
            return $sformatf({"st=%0d kind=%0d rcv=%02h snd=%02h cmd=%02h %02h %02h ",
                              "rep=%02h poff=%0d plen=%0d flen=%0d"},
                             d.status, d.frame_kind, d.dest_node, d.src_node,
                             d.cmd_first, d.cmd_second, d.cmd_third, d.reply_count,
                             d.param_offset, d.param_len, d.frame_length);
        endfunction

        function void fail(string msg);
            fails++;
            if (fails <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_desc(cfsp_pkg::t_desc act);
            cfsp_pkg::t_desc e;
            if (expq.size() == 0) begin
                fail({"descriptor with none expected: ", show(act)});
                return;
            end
            e = expq.pop_front();
            if (act.status !== e.status || act.frame_kind !== e.frame_kind ||
                act.dest_node !== e.dest_node || act.src_node !== e.src_node ||
                act.cmd_first !== e.cmd_first || act.cmd_second !== e.cmd_second ||
                act.cmd_third !== e.cmd_third || act.reply_count !== e.reply_count ||
                act.param_offset !== e.param_offset || act.param_len !== e.param_len ||
                act.frame_length !== e.frame_length)
                fail({"expected ", show(e), " got ", show(act)});
        endfunction

        function void finish();
            if (expq.size() != 0)
                fail($sformatf("%0d descriptors never arrived", expq.size()));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_status;
    logic       o_frame_kind;
    logic [7:0] o_dest_node;
    logic [7:0] o_src_node;
    logic [7:0] o_cmd_first;
    logic [7:0] o_cmd_second;
    logic [7:0] o_cmd_third;
    logic [7:0] o_reply_count;
    logic [3:0] o_param_offset;
    logic [7:0] o_param_len;
    logic [8:0] o_frame_length;

    frame_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;

    command_frame_splitter_parser_core #(
        .LINE_DEPTH(LINE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_frame_kind  (o_frame_kind),
        .o_dest_node   (o_dest_node),
        .o_src_node    (o_src_node),
        .o_cmd_first   (o_cmd_first),
        .o_cmd_second  (o_cmd_second),
        .o_cmd_third   (o_cmd_third),
        .o_reply_count (o_reply_count),
        .o_param_offset(o_param_offset),
        .o_param_len   (o_param_len),
        .o_frame_length(o_frame_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_byte(i_rx_byte);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_desc({o_status, o_frame_kind, o_dest_node, o_src_node, o_cmd_first,
                           o_cmd_second, o_cmd_third, o_reply_count, o_param_offset,
                           o_param_len, o_frame_length});
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte  = b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic send_term();
        send_byte(cfsp_pkg::CH_SP);
        send_byte(cfsp_pkg::CH_CR);
        send_byte(cfsp_pkg::CH_LF);
    endtask

    function automatic logic [7:0] rand_print();
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    function automatic logic [7:0] rand_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return cfsp_pkg::CH_DASH;
        if (sel < 60) return rand_print();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_receiver();
        case ($urandom_range(7))
            0: return cfsp_pkg::CH_C;
            1: return cfsp_pkg::CH_P;
            2: return cfsp_pkg::CH_M;
            3: return cfsp_pkg::CH_T;
            4: return cfsp_pkg::CH_D;
            5: return cfsp_pkg::CH_G;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_rand_frame();
        int sel;
        sel = $urandom_range(99);
        if (sel < 2) begin
            // line overflow with no frame
            repeat (LINE_DEPTH + $urandom_range(1, 8)) send_byte(rand_print());
            return;
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
        if (sel < 8) begin
            repeat ($urandom_range(1, 12)) send_byte(rand_print());
            send_term();
            return;
        end
        send_byte($urandom_range(1) ? cfsp_pkg::CH_C : cfsp_pkg::CH_R);
        send_byte(cfsp_pkg::CH_DASH);
        send_byte(pick_receiver());
        // broken header now and then
        send_byte(sel < 12 ? rand_print() : cfsp_pkg::CH_DASH);
        send_byte(8'($urandom_range(255)));
        send_byte(cfsp_pkg::CH_DASH);
        if (sel < 16) begin
            repeat ($urandom_range(0, 2)) send_byte(rand_print());
            send_term();
            return;
        end
        repeat (3) send_byte(rand_cmd());
        case ($urandom_range(2))
            1: send_byte(cfsp_pkg::CH_DASH);
            2: begin
                send_byte(cfsp_pkg::CH_DASH);
                send_byte(8'($urandom_range(255)));
                send_byte(cfsp_pkg::CH_DASH);
            end
            default: ;
        endcase
        repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(255)));
        send_term();
    endtask

    task automatic send_directed();
        send_str("xy");
        send_term();
        send_str("c-p-g-");
        send_term();
        send_str("r-m-t-abc-7-hello");
        send_term();
        send_str("c-d-c-xyz-param");
        send_term();
        send_str("c-q-c-abc");
        send_term();
        send_str("zzc-m-p-ab r-g-d-xyz");
        send_term();
        // extreme byte values in every captured field
        send_byte(cfsp_pkg::CH_R);
        send_byte(cfsp_pkg::CH_DASH);
        send_byte(8'hFF);
        send_byte(cfsp_pkg::CH_DASH);
        send_byte(8'h00);
        send_byte(cfsp_pkg::CH_DASH);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(cfsp_pkg::CH_DASH);
        send_byte(8'hFF);
        send_byte(cfsp_pkg::CH_DASH);
        send_byte(8'h00);
        send_term();
        // longest frame that fits the line
        send_str("c-m-t-abc-");
        repeat (LINE_DEPTH - 13) send_byte(8'h78);
        send_term();
        repeat (LINE_DEPTH + 1) send_byte(8'h61);
        send_str("c-c-c-eee");
        send_term();
        // header pieces split across a line restart
        send_str("c-t-g-a");
        send_term();
        send_str("-b-");
        send_term();
    endtask

    initial begin
        int target;
        int guard;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = 8'h00;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct  = 15;
        recv_stall_pct = 53;
        send_directed();
        target = bytes_sent + 180;
        while (bytes_sent < target) send_rand_frame();

        send_idle_pct  = 53;
        recv_stall_pct = 15;
        target = bytes_sent + 180;
        while (bytes_sent < target) send_rand_frame();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        target = bytes_sent + 180;
        while (bytes_sent < target) send_rand_frame();
        i_in_valid = 1'b0;

        guard = 0;
        while (sb.expq.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        sb.finish();
        if (sb.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cfsp_pkg.sv
rtl/cfsp_track.sv
rtl/cfsp_desc.sv
rtl/command_frame_splitter_parser_core.sv
rtl/cfsp_checker.sv
tb/sv/command_frame_splitter_parser_core_tb.sv
